/* src/esm_pkg.sv */
package esm_pkg;

    localparam int CAPTURE_FIELD_W = 16;
    localparam int CFG_PPR_W       = 16;
    localparam int CFG_RELOAD_W    = 16;
    localparam int CFG_TICK_W      = 27;
    localparam int SPEED_W         = 32;

    // 60 s/min * 256 fraction steps
    localparam int SCALE_W         = 14;
    localparam logic [SCALE_W-1:0] SPEED_SCALE = 14'd15360;
    localparam int NUM_W           = CFG_TICK_W + SCALE_W;
    localparam int DIV_CNT_W       = $clog2(NUM_W + 1);

    localparam int APB_ADDR_W      = 4;
    localparam int APB_DATA_W      = 32;

    typedef enum logic [1:0] {
        CMD_CAP_A = 2'd0,
        CMD_CAP_B = 2'd1,
        CMD_OVF   = 2'd2,
        CMD_QUERY = 2'd3
    } esm_cmd_t;

    typedef enum logic [1:0] {
        CH_NONE = 2'd0,
        CH_A    = 2'd1,
        CH_B    = 2'd2
    } esm_chan_t;

    typedef enum logic [1:0] {
        REG_PPR    = 2'd0,
        REG_RELOAD = 2'd1,
        REG_TICK   = 2'd2
    } esm_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SPAN,
        ST_CHECK,
        ST_DIV1,
        ST_DIV2_START,
        ST_DIV2,
        ST_DONE
    } esm_state_t;

    typedef struct packed {
        esm_cmd_t                   command;
        logic [CAPTURE_FIELD_W-1:0] capture_value;
    } esm_in_t;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic               speed_valid;
    } esm_out_t;

    typedef struct packed {
        logic item_accept;
        logic prep_en;
        logic span_en;
        logic div_start;
        logic div_sel;
        logic result_load;
    } esm_ctl_t;

    typedef struct packed {
        logic span_ok;
        logic div_busy;
        logic out_free;
    } esm_sts_t;

endpackage

/* src/esm_divider.sv */
module esm_divider
    import esm_pkg::*;
#(
    parameter int DVS_W = 33
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [NUM_W-1:0] quotient
);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0]     quot_reg;
    logic [DVS_W-1:0]     rem_reg;
    logic [DVS_W-1:0]     dvs_reg;
    logic [DVS_W-1:0]     rem_next;
    logic [DVS_W:0]       trial;
    logic [DVS_W:0]       trial_diff;
    logic                 qbit;

    always_comb begin
        trial      = {rem_reg, quot_reg[NUM_W-1]};
        trial_diff = trial - {1'b0, dvs_reg};
        qbit       = (trial >= {1'b0, dvs_reg});
        rem_next   = qbit ? trial_diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(NUM_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            quot_reg <= {quot_reg[NUM_W-2:0], qbit};
            rem_reg  <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule

/* src/esm_datapath.sv */
module esm_datapath
    import esm_pkg::*;
#(
    parameter int COUNTER_WIDTH  = 16,
    parameter int OVERFLOW_WIDTH = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  esm_in_t                 s_data,
    input  logic                    m_ready,
    output logic                    m_valid,
    output esm_out_t                m_data,
    input  logic [CFG_PPR_W-1:0]    pulses_per_rev,
    input  logic [CFG_RELOAD_W-1:0] reload_period,
    input  logic [CFG_TICK_W-1:0]   tick_rate_hz,
    input  esm_ctl_t                ctl,
    output esm_sts_t                sts
);

    localparam int CAP_W  = (COUNTER_WIDTH < CAPTURE_FIELD_W) ? COUNTER_WIDTH : CAPTURE_FIELD_W;
    localparam int PROD_W = OVERFLOW_WIDTH + CFG_RELOAD_W;
    localparam int SPAN_W = PROD_W + 2;
    localparam int DVS_W  = PROD_W + 1;

    logic [CAP_W-1:0]          capture_a_reg;
    logic [CAP_W-1:0]          capture_b_reg;
    esm_chan_t                 latest_reg;
    logic [OVERFLOW_WIDTH-1:0] ovf_reg;

    logic [NUM_W-1:0]          num_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic signed [CAP_W:0]     diff_reg;
    logic signed [CAP_W:0]     diff_next;
    logic signed [SPAN_W-1:0]  span_reg;
    logic signed [SPAN_W-1:0]  span_next;
    logic                      span_ok_reg;
    logic                      span_ok_next;

    logic [CAP_W-1:0]          newest;
    logic [CAP_W-1:0]          other;

    logic                      div_busy;
    logic [NUM_W-1:0]          div_quot;
    logic [NUM_W-1:0]          div_dividend;
    logic [DVS_W-1:0]          div_divisor;

    logic                      m_valid_reg;
    esm_out_t                  m_data_reg;
    logic [SPEED_W-1:0]        speed_sat;

    // channel state, updated on capture and overflow transactions
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capture_a_reg <= '0;
            capture_b_reg <= '0;
            latest_reg    <= CH_NONE;
            ovf_reg       <= '0;
        end else if (ctl.item_accept) begin
            unique case (s_data.command)
                CMD_CAP_A: begin
                    capture_a_reg <= s_data.capture_value[CAP_W-1:0];
                    latest_reg    <= CH_A;
                    ovf_reg       <= '0;
                end
                CMD_CAP_B: begin
                    capture_b_reg <= s_data.capture_value[CAP_W-1:0];
                    latest_reg    <= CH_B;
                    ovf_reg       <= '0;
                end
                CMD_OVF: begin
                    if (ovf_reg != {OVERFLOW_WIDTH{1'b1}}) begin
                        ovf_reg <= ovf_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        newest    = (latest_reg == CH_B) ? capture_b_reg : capture_a_reg;
        other     = (latest_reg == CH_B) ? capture_a_reg : capture_b_reg;
        diff_next = $signed({1'b0, newest}) - $signed({1'b0, other});
        if (diff_next[CAP_W] && (ovf_reg == '0)) begin
            diff_next = -diff_next;
        end
        span_next    = SPAN_W'(diff_reg) + $signed({2'b00, prod_reg});
        span_ok_next = (latest_reg != CH_NONE) && !span_next[SPAN_W-1]
                       && (span_next != '0) && (pulses_per_rev != '0);
    end

    always_ff @(posedge aclk) begin
        if (ctl.prep_en) begin
            num_reg  <= NUM_W'(tick_rate_hz) * NUM_W'(SPEED_SCALE);
            prod_reg <= PROD_W'(ovf_reg) * PROD_W'(reload_period);
            diff_reg <= diff_next;
        end
        if (ctl.span_en) begin
            span_reg    <= span_next;
            span_ok_reg <= span_ok_next;
        end
    end

    // first pass divides by pulses per rev, second by the span
    assign div_dividend = ctl.div_sel ? div_quot : num_reg;
    assign div_divisor  = ctl.div_sel ? span_reg[DVS_W-1:0] : DVS_W'(pulses_per_rev);

    esm_divider #(
        .DVS_W(DVS_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctl.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    assign speed_sat = (div_quot[NUM_W-1:SPEED_W] != '0) ? {SPEED_W{1'b1}}
                                                         : div_quot[SPEED_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.result_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.result_load) begin
            m_data_reg.speed       <= span_ok_reg ? speed_sat : '0;
            m_data_reg.speed_valid <= span_ok_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;
    assign sts.span_ok  = span_ok_reg;
    assign sts.div_busy = div_busy;
    assign sts.out_free = !m_valid_reg || m_ready;

endmodule

/* src/esm_ctrl.sv */
module esm_ctrl
    import esm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  esm_cmd_t command,
    output logic     s_ready,
    input  esm_sts_t sts,
    output esm_ctl_t ctl
);

    esm_state_t state_reg;
    esm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && (command == CMD_QUERY)) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:  state_next = ST_SPAN;
            ST_SPAN:  state_next = ST_CHECK;
            ST_CHECK: state_next = sts.span_ok ? ST_DIV1 : ST_DONE;
            ST_DIV1: begin
                if (!sts.div_busy) begin
                    state_next = ST_DIV2_START;
                end
            end
            ST_DIV2_START: state_next = ST_DIV2;
            ST_DIV2: begin
                if (!sts.div_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready         = (state_reg == ST_IDLE);
        ctl.item_accept = s_ready && s_valid;
        ctl.prep_en     = (state_reg == ST_PREP);
        ctl.span_en     = (state_reg == ST_SPAN);
        ctl.div_start   = ((state_reg == ST_CHECK) && sts.span_ok)
                          || (state_reg == ST_DIV2_START);
        ctl.div_sel     = (state_reg == ST_DIV2_START);
        ctl.result_load = (state_reg == ST_DONE) && sts.out_free;
    end

endmodule

/* src/encoder_capture_speed_meter.sv */
// capture and overflow transactions: no result, back to back
// speed query: m_valid is set after two 41-step restoring divisions in the shared
// divider; both divisions are skipped when the span is invalid
// one transaction at a time: input ready again the cycle after the result is loaded,
// which waits only while an earlier result is still held in the output register
// reset (aresetn low, synchronous): state cleared, registers back to 1024/65535/1 MHz
module encoder_capture_speed_meter
    import esm_pkg::*;
#(
    parameter int COUNTER_WIDTH  = 16,
    parameter int OVERFLOW_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  esm_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output esm_out_t              m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CFG_PPR_W-1:0]    ppr_reg;
    logic [CFG_RELOAD_W-1:0] reload_reg;
    logic [CFG_TICK_W-1:0]   tick_reg;
    logic                    cfg_write;
    esm_reg_t                cfg_sel;
    esm_ctl_t                ctl;
    esm_sts_t                sts;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = esm_reg_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ppr_reg    <= CFG_PPR_W'(1024);
            reload_reg <= CFG_RELOAD_W'(65535);
            tick_reg   <= CFG_TICK_W'(1000000);
        end else if (cfg_write) begin
            case (cfg_sel)
                REG_PPR:    ppr_reg    <= pwdata[CFG_PPR_W-1:0];
                REG_RELOAD: reload_reg <= pwdata[CFG_RELOAD_W-1:0];
                REG_TICK:   tick_reg   <= pwdata[CFG_TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_PPR:    prdata = APB_DATA_W'(ppr_reg);
            REG_RELOAD: prdata = APB_DATA_W'(reload_reg);
            REG_TICK:   prdata = APB_DATA_W'(tick_reg);
            default:    prdata = '0;
        endcase
    end

    esm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .command (s_data.command),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    esm_datapath #(
        .COUNTER_WIDTH  (COUNTER_WIDTH),
        .OVERFLOW_WIDTH (OVERFLOW_WIDTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_data         (s_data),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_data         (m_data),
        .pulses_per_rev (ppr_reg),
        .reload_period  (reload_reg),
        .tick_rate_hz   (tick_reg),
        .ctl            (ctl),
        .sts            (sts)
    );

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.result_load |-> (!m_valid || m_ready))
        else $error("result overwritten while waiting");

    a_invalid_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.speed_valid) |-> (m_data.speed == '0))
        else $error("invalid speed not zero");

    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_busy |-> !s_ready)
        else $error("input ready during division");

    a_query_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.command == CMD_QUERY)) |=> !s_ready)
        else $error("input ready right after query");

endmodule
